[design/fmv_pkg.sv]
// Shared types, constants and constant tables of the two-operator FM voice.
package fmv_pkg;

  localparam int SINE_TABLE_DEPTH = 1024;
  localparam int PHASE_BITS       = 32;
  localparam int SAMPLE_RATE      = 44100;

  localparam int SINE_IDX_W  = $clog2(SINE_TABLE_DEPTH);
  localparam int NOTE_COUNT  = 128;
  localparam int RATIO_W     = 16;
  localparam int STEP_MUL_W  = PHASE_BITS + RATIO_W;
  localparam int MAG_W       = 22;
  localparam int RECIP_SHIFT = 30;
  localparam int RECIP_MUL_W = MAG_W + 24;
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int APB_ADDR_W  = 4;

  // Floor of 2^30 / 127; the quotient estimate is then low by at most one.
  localparam logic [23:0] RECIP_127 = 24'((64'd1 << RECIP_SHIFT) / 64'd127);

  localparam logic [15:0] CARRIER_RATIO_RESET = 16'd256;
  localparam logic [15:0] MOD_RATIO_RESET     = 16'd256;
  localparam logic [15:0] MOD_DEPTH_RESET     = 16'd0;

  localparam logic [1:0] FUNC_TICK     = 2'd0;
  localparam logic [1:0] FUNC_NOTE_ON  = 2'd1;
  localparam logic [1:0] FUNC_NOTE_OFF = 2'd2;

  localparam logic [1:0] REG_CARRIER_RATIO = 2'd0;
  localparam logic [1:0] REG_MOD_RATIO     = 2'd1;
  localparam logic [1:0] REG_MOD_DEPTH     = 2'd2;

  localparam logic [63:0] PI_Q30      = 64'd3373259426;
  localparam logic [63:0] TWO_PI_Q30  = 64'd6746518852;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] RATIO_SCALE = 64'd1000000000000;
  localparam logic [63:0] RATE_DEN    = 64'(SAMPLE_RATE) * RATIO_SCALE;

  localparam logic [63:0] SEMITONE [12] = '{
    64'd1000000000000, 64'd1059463094359, 64'd1122462048309, 64'd1189207115003,
    64'd1259921049895, 64'd1334839854170, 64'd1414213562373, 64'd1498307076877,
    64'd1587401051968, 64'd1681792830507, 64'd1781797436281, 64'd1887748625363
  };

  typedef struct packed {
    logic [1:0] func;
    logic [6:0] note;
    logic [6:0] velocity;
  } fmv_in_t;

  typedef struct packed {
    logic signed [15:0] sample;
    logic               gate;
  } fmv_out_t;

  typedef struct packed {
    logic [15:0]        carrier_ratio;
    logic [15:0]        mod_ratio;
    logic signed [15:0] mod_depth;
  } fmv_cfg_t;

  typedef enum logic [1:0] {
    OP_TICK,
    OP_NOTE_ON,
    OP_NOTE_OFF
  } fmv_op_t;

  typedef struct packed {
    fmv_op_t    op;
    logic [6:0] note;
    logic [6:0] velocity;
  } fmv_cmd_t;

  typedef logic signed [15:0] sine_rom_t [SINE_TABLE_DEPTH];
  typedef logic [PHASE_BITS-1:0] base_rom_t [NOTE_COUNT];

  // Q15 sine of entry idx from a fixed-point Taylor series, folded to the
  // first quadrant.
  function automatic logic signed [15:0] sine_entry(int unsigned idx);
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] sum;
    logic signed [63:0] v;
    logic               neg;
    x   = (TWO_PI_Q30 * 64'(idx % SINE_TABLE_DEPTH)) / SINE_TABLE_DEPTH;
    neg = 1'b0;
    if (x >= PI_Q30) begin
      x   = x - PI_Q30;
      neg = 1'b1;
    end
    if (x > HALF_PI_Q30) begin
      x = PI_Q30 - x;
    end
    x2   = (x * x) >> 30;
    term = x;
    sum  = signed'(x);
    term = ((term * x2) >> 30) / 64'd6;
    sum  = sum - signed'(term);
    term = ((term * x2) >> 30) / 64'd20;
    sum  = sum + signed'(term);
    term = ((term * x2) >> 30) / 64'd42;
    sum  = sum - signed'(term);
    term = ((term * x2) >> 30) / 64'd72;
    sum  = sum + signed'(term);
    term = ((term * x2) >> 30) / 64'd110;
    sum  = sum - signed'(term);
    term = ((term * x2) >> 30) / 64'd156;
    sum  = sum + signed'(term);
    term = ((term * x2) >> 30) / 64'd210;
    sum  = sum - signed'(term);
    if (sum < 0) begin
      sum = 64'sd0;
    end
    v = signed'((unsigned'(sum) * 64'd32767 + (64'd1 << 29)) >> 30);
    if (v > 64'sd32767) begin
      v = 64'sd32767;
    end
    return neg ? 16'(-v) : 16'(v);
  endfunction

  function automatic sine_rom_t make_sine_rom();
    sine_rom_t rom;
    for (int i = 0; i < SINE_TABLE_DEPTH; i++) begin
      rom[i] = sine_entry(i);
    end
    return rom;
  endfunction

  // Rounded phase increment of a MIDI note, by binary long division.
  function automatic logic [PHASE_BITS-1:0] note_base(int unsigned n);
    int unsigned m;
    int unsigned s;
    int unsigned oct;
    int unsigned k;
    logic [63:0] num;
    logic [63:0] q;
    logic [63:0] r;
    m   = (n % 128) + 3;
    s   = m % 12;
    oct = m / 12;
    k   = PHASE_BITS + oct - 5;
    num = 64'd440 * SEMITONE[s];
    q   = num / RATE_DEN;
    r   = num % RATE_DEN;
    for (int i = 0; i < 64; i++) begin
      if (i < k) begin
        r = r << 1;
        q = q << 1;
        if (r >= RATE_DEN) begin
          r = r - RATE_DEN;
          q = q | 64'd1;
        end
      end
    end
    return PHASE_BITS'((q + 64'd1) >> 1);
  endfunction

  function automatic base_rom_t make_base_rom();
    base_rom_t rom;
    for (int i = 0; i < NOTE_COUNT; i++) begin
      rom[i] = note_base(i);
    end
    return rom;
  endfunction

  localparam sine_rom_t SINE_ROM = make_sine_rom();
  localparam base_rom_t BASE_ROM = make_base_rom();

endpackage

[design/fmv_regs.sv]
// APB register file holding the frequency ratios and the modulation depth.
module fmv_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [fmv_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready,
  output fmv_pkg::fmv_cfg_t              cfg
);

  logic       wr_en;
  logic [1:0] reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[3:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.carrier_ratio <= fmv_pkg::CARRIER_RATIO_RESET;
      cfg.mod_ratio     <= fmv_pkg::MOD_RATIO_RESET;
      cfg.mod_depth     <= fmv_pkg::MOD_DEPTH_RESET;
    end else if (wr_en) begin
      case (reg_sel)
        fmv_pkg::REG_CARRIER_RATIO: cfg.carrier_ratio <= pwdata[15:0];
        fmv_pkg::REG_MOD_RATIO:     cfg.mod_ratio     <= pwdata[15:0];
        fmv_pkg::REG_MOD_DEPTH:     cfg.mod_depth     <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      fmv_pkg::REG_CARRIER_RATIO: prdata = {16'd0, cfg.carrier_ratio};
      fmv_pkg::REG_MOD_RATIO:     prdata = {16'd0, cfg.mod_ratio};
      fmv_pkg::REG_MOD_DEPTH:     prdata = {16'd0, cfg.mod_depth};
      default:                    prdata = 32'd0;
    endcase
  end

endmodule

[design/fmv_front.sv]
// Front end: accepts input items, classifies them and queues the commands.
module fmv_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  fmv_pkg::fmv_in_t  in_data,
  output logic              cmd_valid,
  input  logic              cmd_ready,
  output fmv_pkg::fmv_cmd_t cmd
);

  fmv_pkg::fmv_cmd_t                queue [fmv_pkg::QUEUE_DEPTH];
  logic [fmv_pkg::QUEUE_PTR_W-1:0] wr_ptr;
  logic [fmv_pkg::QUEUE_PTR_W-1:0] rd_ptr;
  logic [fmv_pkg::QUEUE_CNT_W-1:0] count;
  logic                            known;
  logic                            push;
  logic                            pop;
  fmv_pkg::fmv_cmd_t               decoded;

  always_comb begin
    decoded.note     = in_data.note;
    decoded.velocity = in_data.velocity;
    known            = 1'b1;
    case (in_data.func)
      fmv_pkg::FUNC_TICK:     decoded.op = fmv_pkg::OP_TICK;
      fmv_pkg::FUNC_NOTE_ON:  decoded.op = fmv_pkg::OP_NOTE_ON;
      fmv_pkg::FUNC_NOTE_OFF: decoded.op = fmv_pkg::OP_NOTE_OFF;
      default: begin
        decoded.op = fmv_pkg::OP_TICK;
        known      = 1'b0;
      end
    endcase
  end

  assign in_ready  = (count != fmv_pkg::QUEUE_CNT_W'(fmv_pkg::QUEUE_DEPTH));
  assign cmd_valid = (count != '0);
  assign cmd       = queue[rd_ptr];
  // The unused function code is taken and dropped here.
  assign push      = in_valid && in_ready && known;
  assign pop       = cmd_valid && cmd_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= decoded;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

[design/fmv_back.sv]
// Back end: voice state, sequenced sine lookups and multiplies, result register.
module fmv_back (
  input  logic              clk,
  input  logic              rst,
  input  fmv_pkg::fmv_cfg_t cfg,
  input  logic              cmd_valid,
  output logic              cmd_ready,
  input  fmv_pkg::fmv_cmd_t cmd,
  output logic              out_valid,
  input  logic              out_ready,
  output fmv_pkg::fmv_out_t out_data
);

  typedef enum logic [9:0] {
    ST_IDLE  = 10'b0000000001,
    ST_BASE  = 10'b0000000010,
    ST_STEPC = 10'b0000000100,
    ST_STEPM = 10'b0000001000,
    ST_MSIN  = 10'b0000010000,
    ST_MPROD = 10'b0000100000,
    ST_CSIN  = 10'b0001000000,
    ST_MAG   = 10'b0010000000,
    ST_RECIP = 10'b0100000000,
    ST_FIX   = 10'b1000000000
  } state_t;

  state_t state;
  state_t state_next;

  logic [fmv_pkg::PHASE_BITS-1:0] carrier_phase;
  logic [fmv_pkg::PHASE_BITS-1:0] modulator_phase;
  logic [fmv_pkg::PHASE_BITS-1:0] carrier_step;
  logic [fmv_pkg::PHASE_BITS-1:0] modulator_step;
  logic [6:0]                     amplitude;
  logic                           note_gate;

  logic [6:0]                     note;
  logic [fmv_pkg::PHASE_BITS-1:0] base;
  logic                           tick_gate;
  logic signed [15:0]             sine_q;
  logic signed [31:0]             mod_prod;
  logic                           neg;
  logic [fmv_pkg::MAG_W-1:0]      mag;
  logic [15:0]                    q_est;

  logic [fmv_pkg::SINE_IDX_W-1:0] sine_addr;
  logic [31:0]                    carrier_arg;
  logic [15:0]                    ratio_sel;
  logic [fmv_pkg::STEP_MUL_W-1:0] step_prod;
  logic [fmv_pkg::RECIP_MUL_W-1:0] recip_prod;
  logic [14:0]                    sine_abs;
  logic [fmv_pkg::MAG_W-1:0]      remainder;
  logic [15:0]                    quotient;
  logic                           out_free;

  assign out_free  = !out_valid || out_ready;
  assign cmd_ready = (state == ST_IDLE);

  // Carrier argument: carrier phase plus depth*modsine moved to 32 fractional bits.
  assign carrier_arg = (32'(carrier_phase) << (32 - fmv_pkg::PHASE_BITS))
                     + {mod_prod[25:0], 6'd0};

  always_comb begin
    if (state == ST_MSIN) begin
      sine_addr = modulator_phase[fmv_pkg::PHASE_BITS-1 -: fmv_pkg::SINE_IDX_W];
    end else begin
      sine_addr = carrier_arg[31 -: fmv_pkg::SINE_IDX_W];
    end
  end

  // One multiplier scales the note's base increment by either ratio.
  assign ratio_sel  = (state == ST_STEPC) ? cfg.carrier_ratio : cfg.mod_ratio;
  assign step_prod  = fmv_pkg::STEP_MUL_W'(base) * fmv_pkg::STEP_MUL_W'(ratio_sel);
  assign recip_prod = fmv_pkg::RECIP_MUL_W'(mag) * fmv_pkg::RECIP_MUL_W'(fmv_pkg::RECIP_127);
  assign sine_abs   = sine_q[15] ? 15'(-sine_q) : 15'(sine_q);
  assign remainder  = mag - fmv_pkg::MAG_W'(q_est) * fmv_pkg::MAG_W'(127);
  assign quotient   = (remainder >= fmv_pkg::MAG_W'(127)) ? q_est + 16'd1 : q_est;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (cmd_valid) begin
          case (cmd.op)
            fmv_pkg::OP_TICK:    state_next = ST_MSIN;
            fmv_pkg::OP_NOTE_ON: state_next = ST_BASE;
            default:             state_next = ST_IDLE;
          endcase
        end
      end
      ST_BASE:  state_next = ST_STEPC;
      ST_STEPC: state_next = ST_STEPM;
      ST_STEPM: state_next = ST_IDLE;
      ST_MSIN:  state_next = ST_MPROD;
      ST_MPROD: state_next = ST_CSIN;
      ST_CSIN:  state_next = ST_MAG;
      ST_MAG:   state_next = ST_RECIP;
      ST_RECIP: state_next = ST_FIX;
      ST_FIX: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      carrier_phase   <= '0;
      modulator_phase <= '0;
      carrier_step    <= '0;
      modulator_step  <= '0;
      amplitude       <= '0;
      note_gate       <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      state <= state_next;
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (cmd_valid) begin
            case (cmd.op)
              fmv_pkg::OP_NOTE_ON: begin
                carrier_phase   <= '0;
                modulator_phase <= '0;
                amplitude       <= cmd.velocity;
                note_gate       <= 1'b1;
              end
              fmv_pkg::OP_NOTE_OFF: note_gate <= 1'b0;
              default: ;
            endcase
          end
        end
        ST_STEPC: carrier_step   <= step_prod[8 +: fmv_pkg::PHASE_BITS];
        ST_STEPM: modulator_step <= step_prod[8 +: fmv_pkg::PHASE_BITS];
        ST_FIX: begin
          if (out_free) begin
            out_valid       <= 1'b1;
            carrier_phase   <= carrier_phase + carrier_step;
            modulator_phase <= modulator_phase + modulator_step;
          end
        end
        default: ;
      endcase
    end
  end

  // Working registers of one command.
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        note      <= cmd.note;
        tick_gate <= note_gate;
      end
      ST_BASE:  base <= fmv_pkg::BASE_ROM[note];
      ST_MSIN:  sine_q <= fmv_pkg::SINE_ROM[sine_addr];
      ST_MPROD: mod_prod <= 32'(cfg.mod_depth) * 32'(sine_q);
      ST_CSIN:  sine_q <= fmv_pkg::SINE_ROM[sine_addr];
      ST_MAG: begin
        neg <= sine_q[15];
        mag <= fmv_pkg::MAG_W'(sine_abs) * fmv_pkg::MAG_W'(amplitude)
             + fmv_pkg::MAG_W'(63);
      end
      ST_RECIP: q_est <= recip_prod[fmv_pkg::RECIP_SHIFT +: 16];
      ST_FIX: begin
        if (out_free) begin
          out_data.sample <= neg ? -quotient : quotient;
          out_data.gate   <= tick_gate;
        end
      end
      default: ;
    endcase
  end

endmodule

[design/two_operator_fm_voice.sv]
// Top level of the two-operator FM voice: register port, command queue and voice engine.
//
// Items enter a two-deep command queue and are carried out one at a time by the
// voice engine. For a tick the engine reads the single sine ROM port twice in
// turn (modulator, then carrier), with the depth multiply between the reads and
// the amplitude multiply and divide-by-127 correction after them, before its
// sample lands in the output register. A note-on reads the base ROM, then does
// both step multiplies on one shared multiplier; a note-off just clears the gate,
// and function code 3 is accepted and dropped. While the last sample waits in the
// output register the queue keeps taking items, and the engine holds a finished
// sample until the register frees.
// The registers sit at byte addresses 0 (carrier ratio), 4 (modulator ratio)
// and 8 (modulation depth) and are meant to be written while the voice is idle.
module two_operator_fm_voice (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  fmv_pkg::fmv_in_t               in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output fmv_pkg::fmv_out_t              out_data,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [fmv_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);

  fmv_pkg::fmv_cfg_t cfg;
  fmv_pkg::fmv_cmd_t cmd;
  logic              cmd_valid;
  logic              cmd_ready;

  fmv_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  fmv_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd)
  );

  fmv_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

[design/fmv_checker.sv]
// Port-level checks of the FM voice and the bind that attaches them.
module fmv_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input fmv_pkg::fmv_out_t              out_data,
  input logic                           psel,
  input logic                           penable,
  input logic                           pwrite,
  input logic [fmv_pkg::APB_ADDR_W-1:0] paddr,
  input logic [31:0]                    pwdata,
  input logic [31:0]                    prdata,
  input logic                           pready
);

  // After reset the queue is empty and no result is pending.
  a_reset_empty: assert property (@(posedge clk) rst |=> in_ready && !out_valid)
    else $error("queue or output not empty after reset");

  // A stalled result stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // Samples are scaled by vel/127 of a Q15 sine, so the most negative code never shows.
  a_sample_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.sample != 16'sh8000)
    else $error("sample out of range");

  // A write to the carrier ratio reads back right away.
  a_carrier_readback: assert property (@(posedge clk) disable iff (rst)
    (psel && penable && pwrite && pready && paddr[3:2] == fmv_pkg::REG_CARRIER_RATIO)
    ##1 (paddr[3:2] == fmv_pkg::REG_CARRIER_RATIO)
    |-> prdata == {16'd0, $past(pwdata[15:0])})
    else $error("carrier ratio read back wrong");

  // A sample passes through the queue and the engine's states after its item, so none shows right after reset.
  a_quiet_after_reset: assert property (@(posedge clk) rst |=> !out_valid [*6])
    else $error("result too soon after reset");

endmodule

bind two_operator_fm_voice fmv_checker u_fmv_checker (.*);

[test/two_operator_fm_voice_tb.sv]
// Self-checking testbench for the two-operator FM voice: APB setup, item traffic, sample checks.
`timescale 1ns / 100ps

module two_operator_fm_voice_tb;

  // Address 12 decodes to no register, so writes there must be dropped.
  localparam int REG_UNUSED = 3;
  // Function code that the block takes and drops.
  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  // Cycles allowed after the last sample for queued commands that give no sample.
  localparam int SETTLE_CYCLES = 24;

  // Tracks the voice state and holds the samples still owed by the block.
  class fm_voice_scoreboard;
    logic [15:0]        carrier_ratio;
    logic [15:0]        mod_ratio;
    logic signed [15:0] mod_depth;
    logic [31:0]        carrier_phase;
    logic [31:0]        modulator_phase;
    logic [31:0]        carrier_step;
    logic [31:0]        modulator_step;
    logic [6:0]         amplitude;
    logic               note_gate;
    longint unsigned    semitone[12];
    int                 sine_q15[1024];
    fmv_pkg::fmv_out_t  pending_samples[$];
    int                 fail_count;
    int                 sample_count;
    int                 item_count;

    function new();
      semitone = '{64'd1000000000000, 64'd1059463094359, 64'd1122462048309,
                   64'd1189207115003, 64'd1259921049895, 64'd1334839854170,
                   64'd1414213562373, 64'd1498307076877, 64'd1587401051968,
                   64'd1681792830507, 64'd1781797436281, 64'd1887748625363};
      for (int i = 0; i < 1024; i++) begin
        sine_q15[i] = sine_of_entry(i);
      end
      carrier_ratio   = 16'd256;
      mod_ratio       = 16'd256;
      mod_depth       = 16'sd0;
      carrier_phase   = '0;
      modulator_phase = '0;
      carrier_step    = '0;
      modulator_step  = '0;
      amplitude       = '0;
      note_gate       = 1'b0;
      fail_count      = 0;
      sample_count    = 0;
      item_count      = 0;
    endfunction

    // Quarter-wave Taylor series in Q30 radians, scaled to Q15.
    function int sine_of_entry(int i);
      longint unsigned x;
      longint unsigned x2;
      longint unsigned term;
      longint          sum;
      longint          v;
      bit              neg;
      x   = (64'd6746518852 * longint'(i)) / 64'd1024;
      neg = 1'b0;
      if (x >= 64'd3373259426) begin
        x   = x - 64'd3373259426;
        neg = 1'b1;
      end
      if (x > 64'd1686629713) begin
        x = 64'd3373259426 - x;
      end
      x2   = (x * x) >> 30;
      term = x;
      sum  = longint'(x);
      for (int k = 1; k <= 7; k++) begin
        term = ((term * x2) >> 30) / longint'((2 * k) * (2 * k + 1));
        if (k % 2 == 1) begin
          sum = sum - longint'(term);
        end else begin
          sum = sum + longint'(term);
        end
      end
      if (sum < 0) begin
        sum = 0;
      end
      v = (sum * 32767 + 64'sd536870912) >>> 30;
      if (v > 32767) begin
        v = 32767;
      end
      return neg ? -int'(v) : int'(v);
    endfunction

    // Rounded phase increment of a MIDI note, worked out by long division.
    function logic [31:0] base_increment(int n);
      int unsigned     m;
      int unsigned     s;
      int unsigned     octave;
      int unsigned     steps;
      longint unsigned den;
      longint unsigned q;
      longint unsigned r;
      m      = n + 3;
      s      = m % 12;
      octave = m / 12;
      steps  = 27 + octave;
      den    = 64'd44100 * 64'd1000000000000;
      r      = 64'd440 * semitone[s];
      q      = r / den;
      r      = r % den;
      for (int i = 0; i < steps; i++) begin
        r = r << 1;
        q = q << 1;
        if (r >= den) begin
          r = r - den;
          q = q | 64'd1;
        end
      end
      return 32'((q + 64'd1) >> 1);
    endfunction

    function void write_register(int idx, logic [31:0] value);
      case (idx)
        fmv_pkg::REG_CARRIER_RATIO: carrier_ratio = value[15:0];
        fmv_pkg::REG_MOD_RATIO:     mod_ratio     = value[15:0];
        fmv_pkg::REG_MOD_DEPTH:     mod_depth     = value[15:0];
        default: ;
      endcase
    endfunction

    function void note_input(fmv_pkg::fmv_in_t it);
      longint unsigned   base;
      longint            prod;
      logic [31:0]       arg;
      int                msin;
      int                csin;
      int unsigned       mag;
      int                smp;
      fmv_pkg::fmv_out_t exp;
      item_count++;
      case (it.func)
        fmv_pkg::FUNC_NOTE_ON: begin
          base            = base_increment(it.note);
          carrier_step    = 32'((base * carrier_ratio) >> 8);
          modulator_step  = 32'((base * mod_ratio) >> 8);
          carrier_phase   = '0;
          modulator_phase = '0;
          amplitude       = it.velocity;
          note_gate       = 1'b1;
        end
        fmv_pkg::FUNC_NOTE_OFF: begin
          note_gate = 1'b0;
        end
        fmv_pkg::FUNC_TICK: begin
          msin = sine_q15[modulator_phase[31:22]];
          // Depth times sine is a Q26 fraction of a turn; six more bits bring it to Q32.
          prod = longint'(mod_depth) * msin;
          arg  = carrier_phase + 32'(prod * 64);
          csin = sine_q15[arg[31:22]];
          mag  = (csin < 0 ? -csin : csin) * amplitude;
          smp  = (mag + 63) / 127;
          if (csin < 0) begin
            smp = -smp;
          end
          exp.sample = 16'(smp);
          exp.gate   = note_gate;
          pending_samples.push_back(exp);
          carrier_phase   = carrier_phase + carrier_step;
          modulator_phase = modulator_phase + modulator_step;
        end
        default: ;
      endcase
    endfunction

    task report(string msg);
      $display("ERROR at %0t: %s", $realtime, msg);
      fail_count++;
    endtask

    task check_sample(fmv_pkg::fmv_out_t got);
      fmv_pkg::fmv_out_t exp;
      sample_count++;
      if (pending_samples.size() == 0) begin
        report($sformatf("sample %0d gate %0b arrived with none outstanding",
                         got.sample, got.gate));
        return;
      end
      exp = pending_samples.pop_front();
      if (got.sample !== exp.sample) begin
        report($sformatf("sample %0d: got %0d, expected %0d",
                         sample_count, got.sample, exp.sample));
      end
      if (got.gate !== exp.gate) begin
        report($sformatf("sample %0d: gate %0b, expected %0b",
                         sample_count, got.gate, exp.gate));
      end
    endtask
  endclass

  logic                           clk = 1'b0;
  logic                           rst;
  logic                           in_valid;
  logic                           in_ready;
  fmv_pkg::fmv_in_t               in_data;
  logic                           out_valid;
  logic                           out_ready;
  fmv_pkg::fmv_out_t              out_data;
  logic                           psel;
  logic                           penable;
  logic                           pwrite;
  logic [fmv_pkg::APB_ADDR_W-1:0] paddr;
  logic [31:0]                    pwdata;
  logic [31:0]                    prdata;
  logic                           pready;

  fm_voice_scoreboard sb;
  bit                 sender_gaps;
  bit                 receiver_gaps;
  int                 gap_percent;
  int                 stall_percent;
  int                 stall_left;
  int                 setting_count;

  two_operator_fm_voice i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver stalls come in bursts of random length.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_ready = 1'b0;
      stall_left--;
    end else if (receiver_gaps && $urandom_range(0, 99) < stall_percent) begin
      out_ready  = 1'b0;
      stall_left = $urandom_range(0, 2);
    end else begin
      out_ready = 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      sb.check_sample(out_data);
    end
  end

  initial begin
    #3000000;
    $display("Timeout with %0d samples outstanding", sb.pending_samples.size());
    $display("two_operator_fm_voice_tb failed");
    $finish;
  end

  function automatic fmv_pkg::fmv_in_t make_item(logic [1:0] f, int n, int v);
    fmv_pkg::fmv_in_t it;
    it.func     = f;
    it.note     = 7'(n);
    it.velocity = 7'(v);
    return it;
  endfunction

  task automatic apb_write(int idx, logic [31:0] value);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = fmv_pkg::APB_ADDR_W'(4 * idx);
    pwdata  = value;
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    sb.write_register(idx, value);
  endtask

  task automatic check_register(int idx, logic [15:0] want);
    logic [31:0] got;
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = fmv_pkg::APB_ADDR_W'(4 * idx);
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    got = prdata;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    if (got[15:0] !== want) begin
      sb.report($sformatf("register %0d reads %h, expected %h", idx, got[15:0], want));
    end
  endtask

  task automatic configure(logic [15:0] cr, logic [15:0] mr, logic [15:0] md);
    apb_write(fmv_pkg::REG_CARRIER_RATIO, {16'd0, cr});
    apb_write(fmv_pkg::REG_MOD_RATIO, {16'd0, mr});
    apb_write(fmv_pkg::REG_MOD_DEPTH, {16'd0, md});
    apb_write(REG_UNUSED, $urandom);
    check_register(fmv_pkg::REG_CARRIER_RATIO, cr);
    check_register(fmv_pkg::REG_MOD_RATIO, mr);
    check_register(fmv_pkg::REG_MOD_DEPTH, md);
    setting_count++;
  endtask

  task automatic send_item(fmv_pkg::fmv_in_t it);
    int gap;
    gap = 0;
    if (sender_gaps && $urandom_range(0, 99) < gap_percent) begin
      gap = $urandom_range(1, 3);
    end
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = it;
    do @(posedge clk); while (!in_ready);
    sb.note_input(it);
  endtask

  // Stop sending and let every owed sample and any queued command finish.
  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (sb.pending_samples.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Mostly note-on followed by a run of ticks, sometimes a release; the rest is noise.
  task automatic run_notes(int target);
    int               sent;
    int               ticks;
    fmv_pkg::fmv_in_t it;
    sent = 0;
    while (sent < target) begin
      if ($urandom_range(0, 99) < 85) begin
        send_item(make_item(fmv_pkg::FUNC_NOTE_ON, $urandom_range(0, 127),
                            $urandom_range(0, 127)));
        ticks = $urandom_range(1, 24);
        repeat (ticks) send_item(make_item(fmv_pkg::FUNC_TICK, $urandom, $urandom));
        sent += ticks + 1;
        if ($urandom_range(0, 99) < 40) begin
          send_item(make_item(fmv_pkg::FUNC_NOTE_OFF, $urandom, $urandom));
          ticks = $urandom_range(0, 4);
          repeat (ticks) send_item(make_item(fmv_pkg::FUNC_TICK, $urandom, $urandom));
          sent += ticks + 1;
        end
      end else begin
        it = fmv_pkg::fmv_in_t'(16'($urandom));
        send_item(it);
        if (it.func != FUNC_UNUSED) begin
          sent++;
        end
      end
      if ($urandom_range(0, 39) == 0) begin
        drain();
      end
    end
  endtask

  initial begin
    sb            = new();
    rst           = 1'b1;
    in_valid      = 1'b0;
    in_data       = '0;
    out_ready     = 1'b1;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    sender_gaps   = 1'b1;
    receiver_gaps = 1'b1;
    gap_percent   = 20;
    stall_percent = 20;
    stall_left    = 0;
    setting_count = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Reset settings: silent voice first, then the note and velocity extremes.
    send_item(make_item(fmv_pkg::FUNC_TICK, 0, 0));
    send_item(make_item(fmv_pkg::FUNC_NOTE_OFF, 0, 0));
    send_item(make_item(FUNC_UNUSED, 127, 127));
    send_item(make_item(fmv_pkg::FUNC_TICK, 127, 127));
    // A zero velocity still raises the gate but gives silence.
    send_item(make_item(fmv_pkg::FUNC_NOTE_ON, 127, 0));
    repeat (2) send_item(make_item(fmv_pkg::FUNC_TICK, 0, 0));
    send_item(make_item(fmv_pkg::FUNC_NOTE_ON, 0, 127));
    repeat (3) send_item(make_item(fmv_pkg::FUNC_TICK, 127, 0));
    send_item(make_item(fmv_pkg::FUNC_NOTE_ON, 69, 127));
    repeat (4) send_item(make_item(fmv_pkg::FUNC_TICK, 0, 127));
    send_item(make_item(fmv_pkg::FUNC_NOTE_OFF, 127, 127));
    repeat (2) send_item(make_item(fmv_pkg::FUNC_TICK, 0, 0));
    send_item(make_item(fmv_pkg::FUNC_NOTE_ON, 60, 1));
    repeat (2) send_item(make_item(fmv_pkg::FUNC_TICK, 0, 0));
    drain();

    for (int p = 1; p <= 7; p++) begin
      case (p)
        1: configure(16'd0, 16'd0, 16'h8000);
        2: configure(16'hFFFF, 16'hFFFF, 16'h7FFF);
        3: configure(16'd256, 16'd512, 16'd2048);
        default: configure(16'($urandom_range(0, 1023)), 16'($urandom_range(0, 2047)),
                           16'($urandom));
      endcase
      gap_percent   = $urandom_range(0, 2) * 15;
      stall_percent = $urandom_range(0, 2) * 15;
      if (p == 7) begin
        sender_gaps   = 1'b0;
        receiver_gaps = 1'b0;
      end
      run_notes(150);
      drain();
    end

    if (sb.pending_samples.size() != 0) begin
      sb.report($sformatf("%0d samples never arrived", sb.pending_samples.size()));
    end
    $display("Sent %0d items and checked %0d samples over %0d register settings,",
             sb.item_count, sb.sample_count, setting_count + 1);
    $display("covering zero and full-scale ratios, both depth extremes and all commands.");
    if (sb.fail_count == 0) begin
      $display("two_operator_fm_voice_tb passed");
    end else begin
      $display("two_operator_fm_voice_tb failed");
    end
    $finish;
  end

endmodule
